### design/bcdq_pkg.sv
// ----------------------------------------------------------------------------
// bcdq_pkg
// Shared types and codes for the bounded circular deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdq_pkg;

	// width of the size register, the item count and the count output
	localparam int LW = 11;
	// payload width
	localparam int VW = 32;
	// largest size value the register field can carry
	localparam int SIZE_FIELD_MAX = 2047;

	// register indexes
	localparam int REG_LIST_SIZE = 0;

	// command codes
	typedef enum logic [1:0] {
		CMD_PUSH_TOP    = 2'd0,
		CMD_PUSH_BOTTOM = 2'd1,
		CMD_POP_TOP     = 2'd2,
		CMD_POP_BOTTOM  = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_PUSHED    = 3'd0,
		ST_FULL      = 3'd1,
		ST_POP_MORE  = 3'd2,
		ST_POP_EMPTY = 3'd3,
		ST_WAS_EMPTY = 3'd4
	} status_t;

	// per-command result handed from control to the output stage
	typedef struct packed {
		status_t         status;
		logic            is_pop;
		logic [LW-1:0]   count;
	} res_t;

endpackage

`default_nettype wire

### design/bcdq_if.sv
// ----------------------------------------------------------------------------
// bcdq_cmd_if / bcdq_res_if
// Valid/ready channels for deque commands and deque results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdq_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          cmd;
	logic signed [bcdq_pkg::VW-1:0]      value_in;

	modport source (output valid, output cmd, output value_in, input ready);
	modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

interface bcdq_res_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          status;
	logic signed [bcdq_pkg::VW-1:0]      value_out;
	logic [bcdq_pkg::LW-1:0]             item_count;

	modport source (output valid, output status, output value_out, output item_count,
		input ready);
	modport sink   (input valid, input status, input value_out, input item_count,
		output ready);
endinterface

`default_nettype wire

### design/bcdq_cfg.sv
// ----------------------------------------------------------------------------
// bcdq_cfg
// APB register block holding the clamped ring size.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdq_cfg #(
	parameter int SLOT_MAX = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output logic      [bcdq_pkg::LW-1:0]   list_size,
	output logic                           clear
);

	localparam int RESET_SIZE = (SLOT_MAX < 1024) ? SLOT_MAX : 1024;
	localparam logic [bcdq_pkg::LW-1:0] SIZE_MAX = bcdq_pkg::LW'(SLOT_MAX);

	logic [bcdq_pkg::LW-1:0] size_q;
	logic [bcdq_pkg::LW-1:0] wr_raw;
	logic [bcdq_pkg::LW-1:0] wr_clamped;
	logic                    sel_size;

	assign pready   = 1'b1;
	assign sel_size = (paddr[2] == 1'(bcdq_pkg::REG_LIST_SIZE));
	assign clear    = psel && penable && pwrite && sel_size;

	// clamp the written size into 1..SLOT_MAX
	always_comb begin
		wr_raw = pwdata[bcdq_pkg::LW-1:0];
		priority if (wr_raw == '0)
			wr_clamped = bcdq_pkg::LW'(1);
		else if (wr_raw > SIZE_MAX)
			wr_clamped = SIZE_MAX;
		else
			wr_clamped = wr_raw;
	end

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= bcdq_pkg::LW'(RESET_SIZE);
		end else if (clear) begin
			size_q <= wr_clamped;
		end
	end

	// read back
	assign prdata    = sel_size ? {{(32-bcdq_pkg::LW){1'b0}}, size_q} : 32'd0;
	assign list_size = size_q;

endmodule

`default_nettype wire

### design/bcdq_ctrl.sv
// ----------------------------------------------------------------------------
// bcdq_ctrl
// Top pointer and item count, command decode and ring slot selection.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdq_ctrl #(
	parameter int SLOT_MAX = 1024,
	parameter int AW       = 10
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     accept,
	input  wire logic [1:0]               cmd,
	input  wire logic [bcdq_pkg::LW-1:0]  list_size,
	input  wire logic                     clear,
	output bcdq_pkg::res_t                res,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic      [AW-1:0]            mem_addr
);

	localparam int PW = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
	localparam int EW = bcdq_pkg::LW + 1;

	logic [PW-1:0]            top_q;
	logic [bcdq_pkg::LW-1:0]  cnt_q;
	logic [PW-1:0]            top_d;
	logic [bcdq_pkg::LW-1:0]  cnt_d;
	logic                     upd;

	logic [EW-1:0] size_e;
	logic [EW-1:0] top_e;
	logic [EW-1:0] cnt_e;
	logic [EW-1:0] top_inc;
	logic [EW-1:0] top_dec;
	logic [EW-1:0] n_e;
	logic [EW-1:0] bsum;
	logic [EW-1:0] bslot;
	logic          full;
	logic          empty;

	assign size_e = {1'b0, list_size};
	assign top_e  = EW'(top_q);
	assign cnt_e  = {1'b0, cnt_q};
	assign full   = (cnt_q >= list_size);
	assign empty  = (cnt_q == '0);

	// neighbor slots with one wrap each
	assign top_inc = ((top_e + EW'(1)) == size_e) ? '0 : (top_e + EW'(1));
	assign top_dec = (top_e == '0) ? (size_e - EW'(1)) : (top_e - EW'(1));

	// bottom slot for count n: (top + size - n) mod size, n never above size
	assign n_e   = (cmd == bcdq_pkg::CMD_PUSH_BOTTOM) ? (cnt_e + EW'(1)) : cnt_e;
	assign bsum  = top_e + size_e - n_e;
	assign bslot = (bsum >= size_e) ? (bsum - size_e) : bsum;

	// command decode
	always_comb begin
		res.status = bcdq_pkg::ST_PUSHED;
		res.is_pop = 1'b0;
		top_d      = top_q;
		cnt_d      = cnt_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = AW'(top_e);
		unique case (bcdq_pkg::cmd_t'(cmd))
			bcdq_pkg::CMD_PUSH_TOP: begin
				if (full) begin
					res.status = bcdq_pkg::ST_FULL;
				end else begin
					mem_we = 1'b1;
					top_d  = PW'(top_inc);
					cnt_d  = cnt_q + bcdq_pkg::LW'(1);
				end
			end
			bcdq_pkg::CMD_PUSH_BOTTOM: begin
				if (full) begin
					res.status = bcdq_pkg::ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = AW'(bslot);
					cnt_d    = cnt_q + bcdq_pkg::LW'(1);
				end
			end
			bcdq_pkg::CMD_POP_TOP: begin
				if (empty) begin
					res.status = bcdq_pkg::ST_WAS_EMPTY;
				end else begin
					mem_re     = 1'b1;
					res.is_pop = 1'b1;
					mem_addr   = AW'(top_dec);
					top_d      = PW'(top_dec);
					cnt_d      = cnt_q - bcdq_pkg::LW'(1);
					res.status = (cnt_d == '0) ? bcdq_pkg::ST_POP_EMPTY
						: bcdq_pkg::ST_POP_MORE;
				end
			end
			bcdq_pkg::CMD_POP_BOTTOM: begin
				if (empty) begin
					res.status = bcdq_pkg::ST_WAS_EMPTY;
				end else begin
					mem_re     = 1'b1;
					res.is_pop = 1'b1;
					mem_addr   = AW'(bslot);
					cnt_d      = cnt_q - bcdq_pkg::LW'(1);
					res.status = (cnt_d == '0) ? bcdq_pkg::ST_POP_EMPTY
						: bcdq_pkg::ST_POP_MORE;
				end
			end
			default: begin
				res.status = bcdq_pkg::ST_WAS_EMPTY;
			end
		endcase
		res.count = cnt_d;
	end

	assign upd = accept && !clear;

	// pointer and count registers; a size write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			cnt_q <= '0;
		end else if (clear) begin
			top_q <= '0;
			cnt_q <= '0;
		end else if (upd) begin
			top_q <= top_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

`default_nettype wire

### design/bcdq_ring.sv
// ----------------------------------------------------------------------------
// bcdq_ring
// Ring storage: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdq_ring #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic                          re,
	input  wire logic        [AW-1:0]          addr,
	input  wire logic signed [bcdq_pkg::VW-1:0] wdata,
	output logic signed      [bcdq_pkg::VW-1:0] rdata_s1
);

	logic signed [bcdq_pkg::VW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read port, held between pops
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### design/bcdq_out.sv
// ----------------------------------------------------------------------------
// bcdq_out
// Result register plus skid register toward the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdq_out (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire bcdq_pkg::res_t                 res,
	input  wire logic signed [bcdq_pkg::VW-1:0] rdata_s1,
	bcdq_res_if.source                          res_ch
);

	logic                            s1_valid_q;
	bcdq_pkg::res_t                  res_s1;
	logic signed [bcdq_pkg::VW-1:0]  val_s1;
	logic                            skid_valid_q;
	logic [2:0]                      skid_status_q;
	logic signed [bcdq_pkg::VW-1:0]  skid_val_q;
	logic [bcdq_pkg::LW-1:0]         skid_cnt_q;
	logic                            accept;
	logic                            s1_taken;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign s1_taken = s1_valid_q && !skid_valid_q && res_ch.ready;
	assign val_s1   = res_s1.is_pop ? rdata_s1 : '0;

	// control of the two result slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_taken) begin
				s1_valid_q <= 1'b0;
			end
			if (accept && s1_valid_q && !s1_taken) begin
				skid_valid_q <= 1'b1;
			end else if (skid_valid_q && res_ch.ready) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (accept && s1_valid_q && !s1_taken) begin
			skid_status_q <= res_s1.status;
			skid_val_q    <= val_s1;
			skid_cnt_q    <= res_s1.count;
		end
	end

	// older result goes first
	assign res_ch.valid      = skid_valid_q || s1_valid_q;
	assign res_ch.status     = skid_valid_q ? skid_status_q : res_s1.status;
	assign res_ch.value_out  = skid_valid_q ? skid_val_q : val_s1;
	assign res_ch.item_count = skid_valid_q ? skid_cnt_q : res_s1.count;

endmodule

`default_nettype wire

### design/bounded_circular_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_circular_deque_unit
// Double-ended queue of signed 32-bit values in a ring of configurable size.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command per transfer (push or pop at top or bottom,
//   plus the value to push). res_ch returns exactly one result per command:
//   status, popped value (zero unless a pop succeeded) and the item count.
//   The APB port holds list_size at address 0; writing it empties the queue
//   and must only happen while the block is idle.
// Latency and throughput:
//   a result is registered the cycle after its command transfer; one command
//   is taken every cycle while cmd_ch.ready is high, limited by the single
//   ring port, which does one write (push) or one registered read (pop) each.
// Reset:
//   the queue is empty and list_size is 1024 (or DEPTH if smaller). The ring
//   is not cleared; only written slots are ever read back.
// Stall:
//   a result register and a skid register sit before res_ch; with the
//   receiver stalled one more command is taken, then cmd_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_circular_deque_unit #(
	parameter int DEPTH = 1024
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	bcdq_cmd_if.sink          cmd_ch,
	bcdq_res_if.source        res_ch
);

	localparam int SLOT_MAX = (DEPTH < bcdq_pkg::SIZE_FIELD_MAX) ? DEPTH
		: bcdq_pkg::SIZE_FIELD_MAX;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [bcdq_pkg::LW-1:0] list_size;
	logic                    clear;
	logic                    accept;
	bcdq_pkg::res_t          res;
	logic                    mem_we;
	logic                    mem_re;
	logic [AW-1:0]           mem_addr;
	logic signed [bcdq_pkg::VW-1:0] rdata_s1;

	assign accept = cmd_ch.valid && cmd_ch.ready;

	bcdq_cfg #(
		.SLOT_MAX (SLOT_MAX)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.list_size (list_size),
		.clear     (clear)
	);

	bcdq_ctrl #(
		.SLOT_MAX (SLOT_MAX),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd_ch.cmd),
		.list_size (list_size),
		.clear     (clear),
		.res       (res),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr)
	);

	bcdq_ring #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk      (clk),
		.we       (accept && mem_we),
		.re       (accept && mem_re),
		.addr     (mem_addr),
		.wdata    (cmd_ch.value_in),
		.rdata_s1 (rdata_s1)
	);

	bcdq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (cmd_ch.ready),
		.res      (res),
		.rdata_s1 (rdata_s1),
		.res_ch   (res_ch)
	);

endmodule

`default_nettype wire

### design/bcdq_checker.sv
// ----------------------------------------------------------------------------
// bcdq_checker
// Port-level checks on the result channel of the deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdq_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           res_valid,
	input  wire logic                           res_ready,
	input  wire logic [2:0]                     res_status,
	input  wire logic signed [bcdq_pkg::VW-1:0] res_value,
	input  wire logic [bcdq_pkg::LW-1:0]        res_count
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// no value unless a pop succeeded
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == bcdq_pkg::ST_PUSHED
			|| res_status == bcdq_pkg::ST_FULL
			|| res_status == bcdq_pkg::ST_WAS_EMPTY) |-> res_value == '0)
		else $error("nonzero value without a pop");

	// last item popped leaves an empty queue
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == bcdq_pkg::ST_POP_EMPTY |-> res_count == '0)
		else $error("pop reported empty with items left");

	// items remain after a pop that says so, and after a push
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == bcdq_pkg::ST_POP_MORE
			|| res_status == bcdq_pkg::ST_PUSHED
			|| res_status == bcdq_pkg::ST_FULL) |-> res_count != '0)
		else $error("count zero where items must remain");

endmodule

bind bounded_circular_deque_unit bcdq_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_ch.valid),
	.res_ready  (res_ch.ready),
	.res_status (res_ch.status),
	.res_value  (res_ch.value_out),
	.res_count  (res_ch.item_count)
);

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded circular deque unit: commands go in
// through a valid/ready driver, each accepted command runs through a local
// deque predictor, and every result transfer is compared field by field with
// the oldest prediction. The size register is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int RING_DEPTH     = 1024;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 80;
	localparam int MAX_REPORTS    = 10;
	localparam logic [2:0] ADDR_LIST_SIZE = 3'(4 * bcdq_pkg::REG_LIST_SIZE);
	// one past the last register, no register lives here
	localparam logic [2:0] ADDR_SPARE     = 3'(4 * (bcdq_pkg::REG_LIST_SIZE + 1));

	typedef struct {
		bcdq_pkg::cmd_t op;
		logic [31:0]    data;
	} deque_cmd_t;

	typedef struct {
		bcdq_pkg::status_t       status;
		logic [31:0]             value;
		logic [bcdq_pkg::LW-1:0] count;
	} deque_res_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bcdq_cmd_if cmd_ch();
	bcdq_res_if res_ch();

	bounded_circular_deque_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd_ch  (cmd_ch),
		.res_ch  (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirror of the deque state
	logic [31:0] ring_mirror [RING_DEPTH];
	int unsigned top_ptr    = 0;
	int unsigned held_items = 0;
	int unsigned size_live  = RING_DEPTH;

	deque_cmd_t queued_cmds[$];
	deque_res_t predicted_results[$];

	int  items_enqueued = 0;
	int  results_seen   = 0;
	int  mismatches     = 0;
	int  quiet_cycles   = 0;
	int  hold_at        = -1;
	int  send_wait      = 0;
	int  recv_wait      = 0;
	bit  send_idle      = 1'b0;
	bit  recv_idle      = 1'b0;
	bit  cmd_taken      = 1'b0;
	bit  res_taken      = 1'b0;

	// size write: 11-bit field, clamped to 1..RING_DEPTH, queue emptied
	function automatic void size_apply(logic [31:0] word);
		int unsigned v;
		v = word[bcdq_pkg::LW-1:0];
		if (v < 1)
			v = 1;
		else if (v > RING_DEPTH)
			v = RING_DEPTH;
		size_live  = v;
		top_ptr    = 0;
		held_items = 0;
	endfunction

	// one command against the mirror, returns the result it must produce
	function automatic deque_res_t deque_apply(bcdq_pkg::cmd_t op, logic [31:0] data);
		deque_res_t r;
		int unsigned slot;
		r.value = '0;
		if (op == bcdq_pkg::CMD_PUSH_TOP || op == bcdq_pkg::CMD_PUSH_BOTTOM) begin
			if (held_items >= size_live) begin
				r.status = bcdq_pkg::ST_FULL;
			end else if (op == bcdq_pkg::CMD_PUSH_TOP) begin
				ring_mirror[top_ptr] = data;
				top_ptr = (top_ptr + 1) % size_live;
				held_items++;
				r.status = bcdq_pkg::ST_PUSHED;
			end else begin
				held_items++;
				ring_mirror[(top_ptr + size_live - held_items) % size_live] = data;
				r.status = bcdq_pkg::ST_PUSHED;
			end
		end else if (held_items == 0) begin
			r.status = bcdq_pkg::ST_WAS_EMPTY;
		end else begin
			if (op == bcdq_pkg::CMD_POP_TOP) begin
				top_ptr = (top_ptr + size_live - 1) % size_live;
				slot = top_ptr;
			end else begin
				slot = (top_ptr + size_live - held_items) % size_live;
			end
			r.value = ring_mirror[slot];
			held_items--;
			r.status = (held_items > 0) ? bcdq_pkg::ST_POP_MORE : bcdq_pkg::ST_POP_EMPTY;
		end
		r.count = bcdq_pkg::LW'(held_items);
		return r;
	endfunction

	// sample both channels, check results, predict new ones, watchdog
	always @(posedge clk) begin : watch_ports
		deque_res_t want;
		cmd_taken = arst_n === 1'b1 && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1;
		res_taken = arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1;
		if (res_taken) begin
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status %0d value %h count %0d",
						res_ch.status, res_ch.value_out, res_ch.item_count);
			end else begin
				want = predicted_results.pop_front();
				results_seen++;
				if (res_ch.status !== want.status || res_ch.value_out !== want.value ||
					res_ch.item_count !== want.count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch on result %0d: status %0d/%0d value %h/%h count %0d/%0d",
							results_seen, want.status, res_ch.status, want.value,
							res_ch.value_out, want.count, res_ch.item_count);
				end
			end
		end
		if (cmd_taken)
			predicted_results.push_back(
				deque_apply(bcdq_pkg::cmd_t'(cmd_ch.cmd), cmd_ch.value_in));
		// nothing moved on either channel
		if (cmd_taken || res_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// command driver, with a random gap before each transfer when send_idle is set
	always @(negedge clk) begin : drive_cmds
		deque_cmd_t nxt;
		if (arst_n !== 1'b1) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_taken)
				send_wait = send_idle ? $urandom_range(0, 10) : 0;
			if (cmd_ch.valid && !cmd_taken) begin
				// hold the offered command
			end else if (send_wait > 0) begin
				cmd_ch.valid <= 1'b0;
				send_wait--;
			end else if (queued_cmds.size() > 0) begin
				nxt = queued_cmds.pop_front();
				cmd_ch.valid    <= 1'b1;
				cmd_ch.cmd      <= nxt.op;
				cmd_ch.value_in <= nxt.data;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls when recv_idle is set, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_at == results_seen) begin
			recv_wait = LONG_HOLD;
			hold_at   = -1;
		end else if (res_taken) begin
			recv_wait = recv_idle ? $urandom_range(0, 10) : 0;
		end
		if (recv_wait > 0) begin
			res_ch.ready <= 1'b0;
			recv_wait--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic add_cmd(bcdq_pkg::cmd_t op, logic [31:0] data);
		deque_cmd_t c;
		c.op   = op;
		c.data = data;
		queued_cmds.push_back(c);
		items_enqueued++;
	endtask

	// block until every queued command has produced its result
	task automatic wait_drained();
		while (results_seen != items_enqueued)
			@(negedge clk);
	endtask

	// register write, only issued while the block is idle
	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		wait_drained();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (addr == ADDR_LIST_SIZE)
			size_apply(data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random commands in alternating fill and drain stretches
	task automatic run_random(int n, bit s_idle, bit r_idle);
		int             seg;
		bit             fill;
		bcdq_pkg::cmd_t op;
		logic [31:0]    data;
		seg  = 0;
		fill = 1'b0;
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < n; i++) begin
			if (seg == 0) begin
				fill = !fill;
				seg  = $urandom_range(1, (size_live < 20) ? 3 * size_live + 2 : 60);
			end
			seg--;
			if ($urandom_range(0, 3) != 0)
				op = fill ? bcdq_pkg::cmd_t'($urandom_range(0, 1))
					: bcdq_pkg::cmd_t'($urandom_range(2, 3));
			else
				op = fill ? bcdq_pkg::cmd_t'($urandom_range(2, 3))
					: bcdq_pkg::cmd_t'($urandom_range(0, 1));
			case ($urandom_range(0, 15))
				0: data = 32'h7fff_ffff;
				1: data = 32'h8000_0000;
				2: data = 32'h0000_0000;
				3: data = 32'hffff_ffff;
				default: data = $urandom;
			endcase
			add_cmd(op, data);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.cmd      = bcdq_pkg::CMD_PUSH_TOP;
		cmd_ch.value_in = '0;
		res_ch.ready    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset size: pops on empty, extreme values, wrap at both ends
		add_cmd(bcdq_pkg::CMD_POP_TOP, $urandom);
		add_cmd(bcdq_pkg::CMD_POP_BOTTOM, $urandom);
		add_cmd(bcdq_pkg::CMD_PUSH_TOP, 32'h7fff_ffff);
		add_cmd(bcdq_pkg::CMD_PUSH_BOTTOM, 32'h8000_0000);
		add_cmd(bcdq_pkg::CMD_PUSH_TOP, 32'h0000_0000);
		add_cmd(bcdq_pkg::CMD_PUSH_BOTTOM, 32'hffff_ffff);
		add_cmd(bcdq_pkg::CMD_POP_TOP, $urandom);
		add_cmd(bcdq_pkg::CMD_POP_BOTTOM, $urandom);
		add_cmd(bcdq_pkg::CMD_POP_TOP, $urandom);
		add_cmd(bcdq_pkg::CMD_POP_BOTTOM, $urandom);

		// size written as zero acts as one slot: full and now-empty cases
		cfg_write(ADDR_LIST_SIZE, 32'd0);
		add_cmd(bcdq_pkg::CMD_PUSH_BOTTOM, 32'ha5a5_a5a5);
		add_cmd(bcdq_pkg::CMD_PUSH_TOP, 32'h5a5a_5a5a);
		add_cmd(bcdq_pkg::CMD_POP_TOP, $urandom);
		add_cmd(bcdq_pkg::CMD_PUSH_TOP, 32'h1234_5678);
		add_cmd(bcdq_pkg::CMD_PUSH_BOTTOM, 32'h8765_4321);
		add_cmd(bcdq_pkg::CMD_POP_BOTTOM, $urandom);
		add_cmd(bcdq_pkg::CMD_POP_TOP, $urandom);

		// size above range clamps to the full ring; long receiver hold-off
		// with the sender streaming so the input stalls
		cfg_write(ADDR_LIST_SIZE, 32'd2047);
		hold_at = items_enqueued + 20;
		run_random(150, 1'b0, 1'b1);

		// write to an unmapped index must leave the queue untouched
		cfg_write(ADDR_SPARE, 32'd5);
		run_random(60, 1'b1, 1'b1);

		cfg_write(ADDR_LIST_SIZE, 32'd1);
		run_random(80, 1'b1, 1'b1);
		cfg_write(ADDR_LIST_SIZE, 32'd2);
		run_random(80, 1'b1, 1'b0);
		cfg_write(ADDR_LIST_SIZE, 32'd3);
		run_random(100, 1'b0, 1'b1);
		// upper bits above the field are dropped
		cfg_write(ADDR_LIST_SIZE, {21'($urandom), 11'd5});
		run_random(100, 1'b1, 1'b1);
		cfg_write(ADDR_LIST_SIZE, 32'h0000_0800);
		run_random(60, 1'b1, 1'b1);
		cfg_write(ADDR_LIST_SIZE, 32'(RING_DEPTH));
		run_random(100, 1'b0, 1'b0);
		cfg_write(ADDR_LIST_SIZE, 32'd7);
		run_random(80, 1'b1, 1'b1);
		cfg_write(ADDR_LIST_SIZE, 32'($urandom_range(4, 40)));
		run_random(120, 1'b1, 1'b1);
		cfg_write(ADDR_LIST_SIZE, {21'($urandom), 11'($urandom_range(1, 16))});
		hold_at = items_enqueued + 30;
		run_random(120, 1'b0, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
